// File: rtl/bounded_list_engine_defines.svh
// Assertion macros for the checker file of the list engine.
// Depends on nothing; include by bare file name.
`ifndef BOUNDED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define BLE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, on the block's own clock and reset names
`define BLE_ASSERT(lbl, prop, msg) \
   `BLE_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// File: rtl/ble_pkg.sv
// Shared types and constants of the bounded list engine.
// No dependencies.
package ble_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;

   localparam int CMD_W     = 3;
   localparam int ITEM_W    = 32;
   localparam int POS_W     = 5;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT_FRONT = 3'd0,
      CMD_DELETE_FRONT = 3'd1,
      CMD_DELETE_LAST  = 3'd2,
      CMD_DELETE_AT    = 3'd3,
      CMD_DISPLAY      = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SHIFT,
      FSM_DISP
   } fsm_type;

endpackage

// File: rtl/ble_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ble_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bounded_list_engine.sv
// Bounded list engine: circular list of up to DEPTH words in one RAM (ble_pkg, ble_ram).
// Insert/delete front/last: accepted in idle, result registered and valid in the next cycle.
// Delete at position: the entries behind it move up one slot; one read/write a cycle.
// Display: one result per cycle while the output is not stalled, after a registered RAM read, count results in all.
// One command at a time; the next is taken once the sequencer is back in idle and the output is free.
// Synchronous reset empties the list (front 0, count 0); RAM contents are not cleared.
module bounded_list_engine #(
   parameter int DEPTH     = ble_pkg::DEPTH_DEF,
   parameter int WORD_BITS = ble_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ble_pkg::CMD_W-1:0]           req_command,
   input  logic signed [ble_pkg::ITEM_W-1:0]   req_value,
   input  logic [ble_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ble_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ble_pkg::ITEM_W-1:0]   rsp_item,
   output logic [ble_pkg::ENTRIES_W-1:0]       rsp_entries,
   output logic                                rsp_last
);
   import ble_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam int EXW  = (CW > ENTRIES_W) ? CW : ENTRIES_W;
   localparam int IW   = (WORD_BITS > ITEM_W) ? WORD_BITS : ITEM_W;

   fsm_type              state_ff, state_in;
   logic [AW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_slot_ff, pend_slot_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ITEM_W-1:0]    rsp_item_ff, rsp_item_in;
   logic [ENTRIES_W-1:0] rsp_entries_ff, rsp_entries_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   logic                 out_free, accept, load;
   status_type           ld_status;
   logic [ITEM_W-1:0]    ld_item;
   logic                 ld_last;
   logic [CW-1:0]        ld_count;
   logic [CMPW-1:0]      pos_ext, cnt_cmp;
   logic [IW-1:0]        val_ext, rd_ext;
   logic [EXW-1:0]       ent_ext;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = (CW+1)'(f) + (CW+1)'(i);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   ble_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign pos_ext   = CMPW'(req_position);
   assign cnt_cmp   = CMPW'(count_ff);
   assign val_ext   = IW'($unsigned(req_value));
   assign rd_ext    = IW'(ram_rd_data);
   assign ent_ext   = EXW'(ld_count);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = val_ext[WORD_BITS-1:0];
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      load         = 1'b0;
      ld_status    = STAT_OK;
      ld_item      = '0;
      ld_last      = 1'b1;
      ld_count     = count_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_INSERT_FRONT: begin
                     load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        ld_status = STAT_FULL;
                     end else begin
                        front_in    = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = front_in;
                        count_in    = count_ff + CW'(1);
                        ld_count    = count_in;
                     end
                  end
                  CMD_DELETE_FRONT: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        ld_status = STAT_EMPTY;
                     end else begin
                        front_in = slot_of(front_ff, CW'(1));
                        count_in = count_ff - CW'(1);
                        ld_count = count_in;
                     end
                  end
                  CMD_DELETE_LAST: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        ld_status = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        ld_count = count_in;
                     end
                  end
                  CMD_DELETE_AT: begin
                     if (pos_ext == '0 || pos_ext >= cnt_cmp) begin
                        load      = 1'b1;
                        ld_status = STAT_BADPOS;
                     end else begin
                        idx_in   = pos_ext[CW-1:0] + CW'(1);
                        pend_in  = 1'b0;
                        state_in = FSM_SHIFT;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = STAT_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = front_ff;
                        idx_in      = '0;
                        state_in    = FSM_DISP;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         FSM_SHIFT: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_slot_ff;
               ram_wr_data = ram_rd_data;
            end
            if (idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = slot_of(front_ff, idx_ff);
               pend_in      = 1'b1;
               pend_slot_in = slot_of(front_ff, idx_ff - CW'(1));
               idx_in       = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && out_free) begin
                  count_in = count_ff - CW'(1);
                  ld_count = count_in;
                  load     = 1'b1;
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_DISP: begin
            if (out_free) begin
               load    = 1'b1;
               ld_item = rd_ext[ITEM_W-1:0];
               ld_last = (idx_ff + CW'(1)) == count_ff;
               if (ld_last) begin
                  state_in = FSM_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = slot_of(front_ff, idx_ff + CW'(1));
                  idx_in      = idx_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_last_in    = rsp_last_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ld_status;
         rsp_item_in    = ld_item;
         rsp_entries_in = ent_ext[ENTRIES_W-1:0];
         rsp_last_in    = ld_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_item_ff    <= rsp_item_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_item    = rsp_item_ff;
   assign rsp_entries = rsp_entries_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: rtl/ble_checker.sv
// Port-level assertions for the bounded list engine, bound to the top level.
// Depends on ble_pkg and bounded_list_engine_defines.svh.
`include "bounded_list_engine_defines.svh"

module ble_checker #(
   parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ble_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [ble_pkg::ITEM_W-1:0] rsp_item,
   input logic [ble_pkg::ENTRIES_W-1:0]     rsp_entries,
   input logic                              rsp_last
);
   import ble_pkg::*;

   localparam logic [ENTRIES_W-1:0] FULL_ENTRIES = ENTRIES_W'(DEPTH);

   `BLE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item) && $stable(rsp_last), "stalled response transaction changed")
   `BLE_ASSERT(a_err_single, rsp_valid && rsp_status != STAT_OK |-> rsp_last && rsp_item == 0, "error response not a single transaction")
   `BLE_ASSERT(a_empty_count, rsp_valid && rsp_status == STAT_EMPTY |-> rsp_entries == 0, "empty status with entries")
   `BLE_ASSERT(a_full_count, rsp_valid && rsp_status == STAT_FULL |-> rsp_entries == FULL_ENTRIES, "full status below depth")

endmodule

bind bounded_list_engine ble_checker #(.DEPTH(DEPTH)) u_ble_checker (.*);
